>>> hw/rtl/clc_pkg.sv
// Shared types, constants and helper functions for the card number classifier.
// No dependencies; every other file under hw/rtl imports this package.
package clc_pkg;

  localparam int unsigned CARD_W       = 54;
  localparam int unsigned BCD_DIGITS   = 17;
  localparam int unsigned BCD_W        = 4 * BCD_DIGITS;
  localparam int unsigned LUHN_DIGITS  = 16;
  localparam int unsigned DABBLE_STEPS = 6;
  localparam int unsigned DABBLE_STAGES = CARD_W / DABBLE_STEPS;
  localparam int unsigned SUM_W        = 8;

  // Decimal length bounds
  localparam logic [CARD_W-1:0] LOW_13   = CARD_W'(64'd1000000000000);
  localparam logic [CARD_W-1:0] LOW_14   = CARD_W'(64'd10000000000000);
  localparam logic [CARD_W-1:0] LOW_15   = CARD_W'(64'd100000000000000);
  localparam logic [CARD_W-1:0] LOW_16   = CARD_W'(64'd1000000000000000);
  localparam logic [CARD_W-1:0] LIMIT_16 = CARD_W'(64'd10000000000000000);

  typedef logic [1:0] len_t;
  localparam len_t LEN_NONE = 2'd0;
  localparam len_t LEN_13   = 2'd1;
  localparam len_t LEN_15   = 2'd2;
  localparam len_t LEN_16   = 2'd3;

  typedef logic [1:0] verdict_t;
  localparam verdict_t VERDICT_INVALID    = 2'd0;
  localparam verdict_t VERDICT_AMEX       = 2'd1;
  localparam verdict_t VERDICT_MASTERCARD = 2'd2;
  localparam verdict_t VERDICT_VISA       = 2'd3;

  // Word moving through the conversion stages
  typedef struct packed {
    len_t              len;
    logic [BCD_W-1:0]  bcd;
    logic [CARD_W-1:0] bin;
  } clc_tok_t;

  // One shift-and-add-3 step of the binary to BCD conversion
  function automatic clc_tok_t dabble_step(input clc_tok_t t);
    clc_tok_t                 r;
    logic [BCD_W-1:0]         adj;
    logic [BCD_W+CARD_W-1:0]  w;
    begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
        adj[4*i +: 4] = (t.bcd[4*i +: 4] >= 4'd5) ? t.bcd[4*i +: 4] + 4'd3
                                                   : t.bcd[4*i +: 4];
      end
      w     = {adj, t.bin} << 1;
      r.len = t.len;
      r.bcd = w[BCD_W+CARD_W-1:CARD_W];
      r.bin = w[CARD_W-1:0];
      return r;
    end
  endfunction

  // Doubled digit with its two decimal digits added
  function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
    logic [4:0] x;
    begin
      x = {d, 1'b0};
      return (x > 5'd9) ? 4'(x - 5'd9) : x[3:0];
    end
  endfunction

  function automatic logic div10(input logic [SUM_W-1:0] s);
    logic hit;
    begin
      hit = 1'b0;
      for (int k = 0; k <= 25; k++) begin
        if (s == SUM_W'(k * 10)) hit = 1'b1;
      end
      return hit;
    end
  endfunction

endpackage

>>> hw/rtl/clc_front.sv
// Input register stage: classify the decimal length of the card number.
// Depends on clc_pkg.
module clc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [clc_pkg::CARD_W-1:0] up_card,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output clc_pkg::clc_tok_t         dn_tok
);
  import clc_pkg::*;

  logic     valid_r;
  clc_tok_t tok_r;
  clc_tok_t tok_nxt;

  always_comb begin
    tok_nxt.bcd = '0;
    tok_nxt.bin = up_card;
    if (up_card >= LOW_13 && up_card < LOW_14) begin
      tok_nxt.len = LEN_13;
    end else if (up_card >= LOW_15 && up_card < LOW_16) begin
      tok_nxt.len = LEN_15;
    end else if (up_card >= LOW_16 && up_card < LIMIT_16) begin
      tok_nxt.len = LEN_16;
    end else begin
      tok_nxt.len = LEN_NONE;
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_tok   = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

>>> hw/rtl/clc_dabble.sv
// One stage of the binary to BCD pipeline: a fixed number of shift-add-3 steps.
// Depends on clc_pkg.
module clc_dabble (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  clc_pkg::clc_tok_t up_tok,
  output logic              dn_valid,
  input  logic              dn_ready,
  output clc_pkg::clc_tok_t dn_tok
);
  import clc_pkg::*;

  logic     valid_r;
  clc_tok_t tok_r;
  clc_tok_t tok_nxt;

  always_comb begin
    tok_nxt = up_tok;
    for (int s = 0; s < DABBLE_STEPS; s++) begin
      tok_nxt = dabble_step(tok_nxt);
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_tok   = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

>>> hw/rtl/clc_score.sv
// Luhn sum and prefix pick (first stage), mod-10 check and verdict (second stage).
// Depends on clc_pkg.
module clc_score (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  clc_pkg::clc_tok_t   up_tok,
  output logic                dn_valid,
  input  logic                dn_ready,
  output clc_pkg::verdict_t   dn_verdict
);
  import clc_pkg::*;

  // sum stage
  logic             a_valid_r;
  len_t             a_len_r;
  logic [SUM_W-1:0] a_sum_r;
  logic [3:0]       a_lead_r;
  logic [3:0]       a_second_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [3:0]       lead_nxt;
  logic [3:0]       second_nxt;
  logic [3:0]       lane [LUHN_DIGITS];
  logic [4:0]       l1 [8];
  logic [5:0]       l2 [4];
  logic [6:0]       l3 [2];
  logic             a_ready;

  // verdict stage
  logic     b_valid_r;
  verdict_t b_verdict_r;
  verdict_t verdict_nxt;

  always_comb begin
    for (int k = 0; k < LUHN_DIGITS; k++) begin
      lane[k] = (k % 2 == 1) ? luhn_dbl(up_tok.bcd[4*k +: 4]) : up_tok.bcd[4*k +: 4];
    end
    for (int k = 0; k < 8; k++) l1[k] = {1'b0, lane[2*k]} + {1'b0, lane[2*k+1]};
    for (int k = 0; k < 4; k++) l2[k] = {1'b0, l1[2*k]} + {1'b0, l1[2*k+1]};
    for (int k = 0; k < 2; k++) l3[k] = {1'b0, l2[2*k]} + {1'b0, l2[2*k+1]};
    sum_nxt = {1'b0, l3[0]} + {1'b0, l3[1]};
  end

  // lead digit and the one after it, by length
  always_comb begin
    unique case (up_tok.len)
      LEN_13: begin
        lead_nxt   = up_tok.bcd[4*12 +: 4];
        second_nxt = up_tok.bcd[4*11 +: 4];
      end
      LEN_15: begin
        lead_nxt   = up_tok.bcd[4*14 +: 4];
        second_nxt = up_tok.bcd[4*13 +: 4];
      end
      LEN_16: begin
        lead_nxt   = up_tok.bcd[4*15 +: 4];
        second_nxt = up_tok.bcd[4*14 +: 4];
      end
      default: begin
        lead_nxt   = 4'd0;
        second_nxt = 4'd0;
      end
    endcase
  end

  always_comb begin
    verdict_nxt = VERDICT_INVALID;
    if (a_len_r != LEN_NONE && div10(a_sum_r)) begin
      priority if (a_len_r == LEN_15 && a_lead_r == 4'd3 &&
                   (a_second_r == 4'd4 || a_second_r == 4'd7)) begin
        verdict_nxt = VERDICT_AMEX;
      end else if (a_len_r == LEN_16 && a_lead_r == 4'd5 &&
                   a_second_r >= 4'd1 && a_second_r <= 4'd5) begin
        verdict_nxt = VERDICT_MASTERCARD;
      end else if ((a_len_r == LEN_13 || a_len_r == LEN_16) && a_lead_r == 4'd4) begin
        verdict_nxt = VERDICT_VISA;
      end else begin
        verdict_nxt = VERDICT_INVALID;
      end
    end
  end

  assign a_ready    = !b_valid_r || dn_ready;
  assign up_ready   = !a_valid_r || a_ready;
  assign dn_valid   = b_valid_r;
  assign dn_verdict = b_verdict_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (up_ready) a_valid_r <= up_valid;
      if (a_ready)  b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      a_len_r    <= up_tok.len;
      a_sum_r    <= sum_nxt;
      a_lead_r   <= lead_nxt;
      a_second_r <= second_nxt;
    end
    if (a_ready && a_valid_r) begin
      b_verdict_r <= verdict_nxt;
    end
  end

endmodule

>>> hw/rtl/card_number_luhn_classifier.sv
// Top level of the card number classifier: length check, BCD conversion, Luhn score.
// Depends on clc_pkg, clc_front, clc_dabble and clc_score.
//
//   channel | ports                          | direction | word
//   --------+--------------------------------+-----------+-----------------------------
//   in      | in_valid in_stall in_card_number | in      | 54-bit unsigned card number
//   out     | out_valid out_stall out_verdict  | out     | 2-bit verdict (0/1/2/3)
//
// Throughput is one word per cycle when nothing stalls; the stages are:
// one length-check stage, nine binary-to-BCD stages of six shift-add-3 steps
// each, a Luhn sum stage and a verdict stage that also serves as output register.
// rst_n (synchronous, active low) clears every stage's valid bit; data registers
// are not reset. Each stage loads when it is empty or its successor loads, so
// out_stall backs up stage by stage, bubbles close, and no word is lost or doubled.
module card_number_luhn_classifier (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [clc_pkg::CARD_W-1:0] in_card_number,
  output logic                       out_valid,
  input  logic                       out_stall,
  output clc_pkg::verdict_t          out_verdict
);
  import clc_pkg::*;

  // Handshake taps between stages: index 0 leaves the front stage,
  // index s+1 leaves conversion stage s.
  logic     tap_valid [DABBLE_STAGES+1];
  logic     tap_ready [DABBLE_STAGES+1];
  clc_tok_t tap_tok   [DABBLE_STAGES+1];
  logic     front_ready;

  assign in_stall = !front_ready;

  // Length check: flag 13, 15 and 16 digit numbers, seed the conversion word
  clc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (front_ready),
    .up_card  (in_card_number),
    .dn_valid (tap_valid[0]),
    .dn_ready (tap_ready[0]),
    .dn_tok   (tap_tok[0])
  );

  // Binary to BCD: shift the number in six bits per stage
  for (genvar s = 0; s < DABBLE_STAGES; s++) begin : g_dabble
    clc_dabble u_dabble (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (tap_valid[s]),
      .up_ready (tap_ready[s]),
      .up_tok   (tap_tok[s]),
      .dn_valid (tap_valid[s+1]),
      .dn_ready (tap_ready[s+1]),
      .dn_tok   (tap_tok[s+1])
    );
  end

  // Luhn sum, mod-10 check and prefix match; last register drives the outputs
  clc_score u_score (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (tap_valid[DABBLE_STAGES]),
    .up_ready   (tap_ready[DABBLE_STAGES]),
    .up_tok     (tap_tok[DABBLE_STAGES]),
    .dn_valid   (out_valid),
    .dn_ready   (!out_stall),
    .dn_verdict (out_verdict)
  );

endmodule
